// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the rotation pipeline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/par_pkg.sv =====
// Types, constants and helper functions for the principal axis rotation pipeline
`timescale 1ns / 1ps
`default_nettype none
package par_pkg;

	localparam int COORD_W        = 32;
	localparam int TRIG_FRAC_BITS = 16;
	localparam int ANGLE_W        = 16;
	localparam int TRIG_MAG_W     = TRIG_FRAC_BITS + 1;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
	localparam int PROD_W         = COORD_W + TRIG_W;
	localparam int SUM_W          = PROD_W + 1;
	localparam int RND_W          = SUM_W - TRIG_FRAC_BITS;

	localparam int DEG_W    = 9;
	localparam int IDX_W    = 7;
	localparam int DEG_FULL = 360;
	localparam int DEG_HALF = 180;
	localparam int DEG_QTR  = 90;
	localparam int DEG_3QTR = 270;

	// angle reduction: quotient by 360 through a scaled reciprocal
	localparam int ANG_MAG_W    = ANGLE_W + 1;
	localparam int ANG_RECIP_SH = 24;
	localparam int ANG_RECIP    = (1 << ANG_RECIP_SH) / DEG_FULL;
	localparam int ANG_PROD_W   = 2 * ANG_MAG_W;
	localparam int ANG_Q_W      = 7;
	localparam int ANG_REM_W    = DEG_W + 1;

	localparam int QTR_ENTRIES = 91;
	localparam int TBL_W       = 17;
	localparam int TBL_FRAC    = 16;
	localparam int SH_UP       = (TRIG_FRAC_BITS >= TBL_FRAC) ? TRIG_FRAC_BITS - TBL_FRAC : 0;
	localparam int SH_DN       = (TRIG_FRAC_BITS < TBL_FRAC) ? TBL_FRAC - TRIG_FRAC_BITS : 0;
	localparam int HALF_DN     = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;
	localparam int MAG_WORK_W  = TBL_W + TRIG_MAG_W;

	// round(sin(d) * 65536), d = 0..90
	localparam logic [TBL_W-1:0] QSINE [QTR_ENTRIES] = '{
		17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
		17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
		17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
		17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
		17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
		17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
		17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
		17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
		17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
		17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
		17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
		17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
		17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
	};

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z,
		AXIS_NONE
	} axis_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		axis_t                     axis;
	} coords_t;

	typedef struct packed {
		coords_t          pt;
		logic [DEG_W-1:0] deg;
	} ang_t;

	typedef struct packed {
		logic             neg;
		logic [IDX_W-1:0] idx;
	} trig_fold_t;

	typedef struct packed {
		coords_t                   pt;
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
		logic signed [TRIG_W-1:0]  sin_v;
		logic signed [TRIG_W-1:0]  cos_v;
	} mac_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rot_x;
		logic signed [COORD_W-1:0] rot_y;
		logic signed [COORD_W-1:0] rot_z;
		logic                      sat;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] val;
		logic                      sat;
	} sat_t;

	// fold 0..359 degrees onto the quarter table, sign kept apart
	function automatic trig_fold_t fold_angle(input logic [DEG_W-1:0] d);
		trig_fold_t       f;
		logic [DEG_W-1:0] h;
		f.neg = d > DEG_W'(DEG_HALF);
		h = f.neg ? d - DEG_W'(DEG_HALF) : d;
		f.idx = (h > DEG_W'(DEG_QTR)) ? IDX_W'(DEG_W'(DEG_HALF) - h) : IDX_W'(h);
		return f;
	endfunction

	// table magnitude rescaled to TRIG_FRAC_BITS fraction bits
	function automatic logic [TRIG_MAG_W-1:0] trig_mag(input logic [IDX_W-1:0] idx);
		logic [MAG_WORK_W-1:0] m;
		m = MAG_WORK_W'(QSINE[idx]);
		if (SH_DN == 0)
			m = m << SH_UP;
		else
			m = (m + MAG_WORK_W'(HALF_DN)) >> SH_DN;
		return m[TRIG_MAG_W-1:0];
	endfunction

	// clamp a rounded sum to the signed coordinate range
	function automatic sat_t saturate(input logic signed [RND_W-1:0] r);
		sat_t                         s;
		logic [RND_W-COORD_W:0]       hi_bits;
		hi_bits = r[RND_W-1:COORD_W-1];
		s.sat = !((&hi_bits) || !(|hi_bits));
		if (s.sat)
			s.val = r[RND_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		else
			s.val = r[COORD_W-1:0];
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/par_if.sv =====
// Point and result channel interfaces of the rotation block
`timescale 1ns / 1ps
`default_nettype none
interface par_in_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [par_pkg::COORD_W-1:0]        coord_x;
	logic signed [par_pkg::COORD_W-1:0]        coord_y;
	logic signed [par_pkg::COORD_W-1:0]        coord_z;
	logic        [1:0]                         axis_sel;
	logic signed [par_pkg::ANGLE_W-1:0]        angle_deg;

	modport source (output valid, coord_x, coord_y, coord_z, axis_sel, angle_deg,
		input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, axis_sel, angle_deg,
		output ready);
endinterface

interface par_out_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [par_pkg::COORD_W-1:0]        rot_x;
	logic signed [par_pkg::COORD_W-1:0]        rot_y;
	logic signed [par_pkg::COORD_W-1:0]        rot_z;
	logic                                      sat_flag;

	modport source (output valid, rot_x, rot_y, rot_z, sat_flag, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, sat_flag, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/par_angle.sv =====
// Angle reduction stages: signed degrees to 0..359
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module par_angle (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              up_valid,
	output logic                                   up_ready,
	input  wire par_pkg::coords_t                  up_pt,
	input  wire logic signed [par_pkg::ANGLE_W-1:0] up_angle,
	output logic                                   dn_valid,
	input  wire logic                              dn_ready,
	output par_pkg::ang_t                          dn_data
);
	import par_pkg::*;

	logic                     v_s1, v_s2;
	logic                     en_s1, en_s2;
	logic [ANG_MAG_W-1:0]     mag_s1;
	logic [ANG_Q_W-1:0]       q_s1;
	logic                     neg_s1;
	coords_t                  pt_s1;
	ang_t                     ang_s2;

	logic signed [ANG_MAG_W-1:0] ang_ext;
	logic [ANG_MAG_W-1:0]        mag;
	logic [ANG_PROD_W-1:0]       qprod;
	logic [ANG_MAG_W-1:0]        rem0;
	logic [ANG_REM_W-1:0]        rem1;
	logic [DEG_W-1:0]            rem2;
	logic [DEG_W-1:0]            deg;

	assign en_s2    = !v_s2 || dn_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;
	assign dn_valid = v_s2;
	assign dn_data  = ang_s2;

	// magnitude times 2^24/360 underestimates the quotient by at most one
	always_comb begin
		ang_ext = ANG_MAG_W'(up_angle);
		mag     = ang_ext[ANG_MAG_W-1] ? ANG_MAG_W'(-ang_ext) : ANG_MAG_W'(ang_ext);
		qprod   = ANG_PROD_W'(mag) * ANG_PROD_W'(ANG_RECIP);
	end

	// remainder, one correction, then truncated-modulo sign fix
	always_comb begin
		rem0 = mag_s1 - ANG_MAG_W'(ANG_MAG_W'(q_s1) * ANG_MAG_W'(DEG_FULL));
		rem1 = (rem0 >= ANG_MAG_W'(DEG_FULL)) ? ANG_REM_W'(rem0 - ANG_MAG_W'(DEG_FULL))
			: ANG_REM_W'(rem0);
		rem2 = rem1[DEG_W-1:0];
		deg  = (neg_s1 && rem2 != '0) ? DEG_W'(DEG_FULL) - rem2 : rem2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= up_valid;
			if (en_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mag_s1 <= mag;
			q_s1   <= qprod[ANG_RECIP_SH +: ANG_Q_W];
			neg_s1 <= ang_ext[ANG_MAG_W-1];
			pt_s1  <= up_pt;
		end
		if (en_s2) begin
			ang_s2.pt  <= pt_s1;
			ang_s2.deg <= deg;
		end
	end

	`ASSERT_IMPLIES(a_deg_range, clk, arst_n, v_s2, ang_s2.deg < DEG_W'(DEG_FULL), "reduced angle out of range")
	`ASSERT_NEXT(a_accept_fills, clk, arst_n, up_valid && up_ready, v_s1, "accepted word not captured")

endmodule
`default_nettype wire

// ===== hw/rtl/par_trig.sv =====
// Quadrant fold, sine/cosine lookup and operand selection stages
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module par_trig (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire par_pkg::ang_t  up_data,
	output logic                dn_valid,
	input  wire logic           dn_ready,
	output par_pkg::mac_t       dn_data
);
	import par_pkg::*;

	logic             v_s3, v_s4;
	logic             en_s3, en_s4;
	trig_fold_t       sin_f_s3, cos_f_s3;
	coords_t          pt_s3;
	mac_t             mac_s4;

	logic [DEG_W-1:0]         cos_deg;
	logic signed [TRIG_W-1:0] sin_mag, cos_mag;
	mac_t                     mac;

	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign up_ready = en_s3;
	assign dn_valid = v_s4;
	assign dn_data  = mac_s4;

	// cosine is the sine a quarter turn ahead
	assign cos_deg = (up_data.deg >= DEG_W'(DEG_3QTR)) ? up_data.deg - DEG_W'(DEG_3QTR)
		: up_data.deg + DEG_W'(DEG_QTR);

	always_comb begin
		sin_mag   = signed'({1'b0, trig_mag(sin_f_s3.idx)});
		cos_mag   = signed'({1'b0, trig_mag(cos_f_s3.idx)});
		mac.pt    = pt_s3;
		mac.sin_v = sin_f_s3.neg ? -sin_mag : sin_mag;
		mac.cos_v = cos_f_s3.neg ? -cos_mag : cos_mag;
		// u' = u*c - v*s, v' = u*s + v*c in every rotating plane
		case (pt_s3.axis)
			AXIS_X: begin
				mac.u = pt_s3.y;
				mac.v = pt_s3.z;
			end
			AXIS_Y: begin
				mac.u = pt_s3.z;
				mac.v = pt_s3.x;
			end
			AXIS_Z: begin
				mac.u = pt_s3.x;
				mac.v = pt_s3.y;
			end
			default: begin
				mac.u = pt_s3.x;
				mac.v = pt_s3.y;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3)
				v_s3 <= up_valid;
			if (en_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sin_f_s3 <= fold_angle(up_data.deg);
			cos_f_s3 <= fold_angle(cos_deg);
			pt_s3    <= up_data.pt;
		end
		if (en_s4)
			mac_s4 <= mac;
	end

	`ASSERT_IMPLIES(a_idx_range, clk, arst_n, v_s3, (sin_f_s3.idx <= IDX_W'(DEG_QTR)) && (cos_f_s3.idx <= IDX_W'(DEG_QTR)), "table index past quarter wave")

endmodule
`default_nettype wire

// ===== hw/rtl/par_mac.sv =====
// Product, round and saturate stages with the output register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module par_mac (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire par_pkg::mac_t  up_data,
	output logic                dn_valid,
	input  wire logic           dn_ready,
	output par_pkg::result_t    dn_data
);
	import par_pkg::*;

	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);

	logic                     v_s5, v_s6;
	logic                     en_s5, en_s6;
	logic signed [PROD_W-1:0] uc_s5, vs_s5, us_s5, vc_s5;
	coords_t                  pt_s5;
	result_t                  res_s6;

	logic signed [SUM_W-1:0]  acc_u, acc_v;
	logic signed [RND_W-1:0]  rnd_u, rnd_v;
	sat_t                     sat_u, sat_v;
	result_t                  res;

	assign en_s6    = !v_s6 || dn_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign up_ready = en_s5;
	assign dn_valid = v_s6;
	assign dn_data  = res_s6;

	always_comb begin
		acc_u = SUM_W'(uc_s5) - SUM_W'(vs_s5) + RND_HALF;
		acc_v = SUM_W'(us_s5) + SUM_W'(vc_s5) + RND_HALF;
		rnd_u = acc_u[SUM_W-1:TRIG_FRAC_BITS];
		rnd_v = acc_v[SUM_W-1:TRIG_FRAC_BITS];
		sat_u = saturate(rnd_u);
		sat_v = saturate(rnd_v);
		res.rot_x = pt_s5.x;
		res.rot_y = pt_s5.y;
		res.rot_z = pt_s5.z;
		res.sat   = sat_u.sat || sat_v.sat;
		// put the plane results back on their axes
		case (pt_s5.axis)
			AXIS_X: begin
				res.rot_y = sat_u.val;
				res.rot_z = sat_v.val;
			end
			AXIS_Y: begin
				res.rot_z = sat_u.val;
				res.rot_x = sat_v.val;
			end
			AXIS_Z: begin
				res.rot_x = sat_u.val;
				res.rot_y = sat_v.val;
			end
			default: begin
				res.sat = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5)
				v_s5 <= up_valid;
			if (en_s6)
				v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			uc_s5 <= up_data.u * up_data.cos_v;
			vs_s5 <= up_data.v * up_data.sin_v;
			us_s5 <= up_data.u * up_data.sin_v;
			vc_s5 <= up_data.v * up_data.cos_v;
			pt_s5 <= up_data.pt;
		end
		if (en_s6)
			res_s6 <= res;
	end

	`ASSERT_IMPLIES(a_identity_nosat, clk, arst_n, v_s5 && pt_s5.axis == AXIS_NONE, !res.sat, "identity point flagged saturated")
	`ASSERT_NEXT(a_x_axis_keeps_x, clk, arst_n, en_s6 && v_s5 && pt_s5.axis == AXIS_X, res_s6.rot_x == $past(pt_s5.x), "x rotation changed x")

endmodule
`default_nettype wire

// ===== hw/rtl/principal_axis_rotation.sv =====
// Rotation of one 3D point about a principal axis by whole degrees.
//
// Channels: point (sink) takes coord_x/y/z as signed Q15.16, axis_sel
// (0 x, 1 y, 2 z, 3 pass-through) and angle_deg, any signed value, reduced
// mod 360. result (source) gives rot_x/y/z, rounded and clamped to 32 bits,
// and sat_flag when any coordinate was clamped. A word moves on a clock
// edge with valid and ready both high.
// Throughput: one point per cycle while result.ready stays high; every stage
// register is followed by independent logic, so no state ties one point to
// the next.
// Stages: quotient by 360, remainder, quadrant fold, sine/cosine table,
// four parallel 32x18 products, round and saturate into the output register.
// Stall: each stage holds when full and its successor is blocked, so empty
// stages keep filling while a result waits; point.ready drops only when all
// six stages hold words.
// Reset: arst_n clears every stage valid bit at once, so point.ready is high
// and the block accepts points straight after release.
`timescale 1ns / 1ps
`default_nettype none
module principal_axis_rotation (
	input  wire logic  clk,
	input  wire logic  arst_n,
	par_in_if.sink     point,
	par_out_if.source  result
);
	import par_pkg::*;

	coords_t  pt_in;
	logic     ang_ready, ang_valid;
	ang_t     ang_data;
	logic     trig_ready, trig_valid;
	mac_t     trig_data;
	logic     mac_ready;
	result_t  res;

	assign pt_in.x    = point.coord_x;
	assign pt_in.y    = point.coord_y;
	assign pt_in.z    = point.coord_z;
	assign pt_in.axis = axis_t'(point.axis_sel);
	assign point.ready = ang_ready;

	par_angle u_angle (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (point.valid),
		.up_ready (ang_ready),
		.up_pt    (pt_in),
		.up_angle (point.angle_deg),
		.dn_valid (ang_valid),
		.dn_ready (trig_ready),
		.dn_data  (ang_data)
	);

	par_trig u_trig (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ang_valid),
		.up_ready (trig_ready),
		.up_data  (ang_data),
		.dn_valid (trig_valid),
		.dn_ready (mac_ready),
		.dn_data  (trig_data)
	);

	par_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (trig_valid),
		.up_ready (mac_ready),
		.up_data  (trig_data),
		.dn_valid (result.valid),
		.dn_ready (result.ready),
		.dn_data  (res)
	);

	assign result.rot_x    = res.rot_x;
	assign result.rot_y    = res.rot_y;
	assign result.rot_z    = res.rot_z;
	assign result.sat_flag = res.sat;

endmodule
`default_nettype wire
